[rtl/core/esl_pkg.sv]
// esl_pkg: payload types, register indexes, arming phase codes and fixed
// constants for the ESC arming and slew limiter block.
// No dependencies; compile first.
package esl_pkg;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int Q14_SHIFT = 14;

    localparam logic signed [15:0] Q14_ONE       = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG_ONE   = -16'sd16384;
    localparam logic signed [15:0] ARM_THRESHOLD = 16'sd163;

    localparam logic [1:0] PHASE_DISARMED = 2'd0;
    localparam logic [1:0] PHASE_ARMING   = 2'd1;
    localparam logic [1:0] PHASE_ARMED    = 2'd2;

    localparam logic [2:0] REG_SERVO_CENTER  = 3'd0;
    localparam logic [2:0] REG_SERVO_DEFLECT = 3'd1;
    localparam logic [2:0] REG_SERVO_SLEW    = 3'd2;
    localparam logic [2:0] REG_ESC_IDLE      = 3'd3;
    localparam logic [2:0] REG_ESC_MAX       = 3'd4;
    localparam logic [2:0] REG_ESC_ARM_PULSE = 3'd5;
    localparam logic [2:0] REG_ESC_SLEW      = 3'd6;
    localparam logic [2:0] REG_ARM_TIME_MS   = 3'd7;

    localparam logic [11:0] RST_SERVO_CENTER  = 12'd1500;
    localparam logic [10:0] RST_SERVO_DEFLECT = 11'd400;
    localparam logic [11:0] RST_SERVO_SLEW    = 12'd20;
    localparam logic [11:0] RST_ESC_IDLE      = 12'd1000;
    localparam logic [11:0] RST_ESC_MAX       = 12'd2000;
    localparam logic [11:0] RST_ESC_ARM_PULSE = 12'd1000;
    localparam logic [11:0] RST_ESC_SLEW      = 12'd10;
    localparam logic [15:0] RST_ARM_TIME_MS   = 16'd2000;

    typedef struct packed {
        logic signed [15:0] steer;
        logic signed [15:0] throttle;
        logic               failsafe;
        logic [31:0]        now_ms;
    } esl_cmd_t;

    typedef struct packed {
        logic [11:0] rudder_pulse_us;
        logic [11:0] motor_pulse_us;
        logic [1:0]  arm_status;
    } esl_pulse_t;

endpackage

[rtl/core/esl_if.sv]
// esl_cmd_if / esl_pulse_if: valid/ready channels carrying one command word
// and one pulse word. Depends on esl_pkg.
interface esl_cmd_if
    import esl_pkg::*;
();
    logic     valid;
    logic     ready;
    esl_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esl_pulse_if
    import esl_pkg::*;
();
    logic       valid;
    logic       ready;
    esl_pulse_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/esc_arming_slew_limiter.sv]
// esc_arming_slew_limiter: rudder and ESC pulse generator with arming gate
// and per-tick slew limiting. Depends on esl_pkg and esl_if.sv.
//
// One command word per control tick goes in on cmd_ch; one pulse word per
// command comes out on pulse_ch. The block sustains one word per clock
// cycle while pulse_ch is ready: the arming phase and the two pulse
// registers are read and written back in the same cycle, so that state
// update loop sets the rate. An accepted command is captured in an input
// register; when the result slot is free or draining, the clamp, arming,
// scale, limit and slew logic updates the state registers, which drive
// the result word directly and mark it valid. A new command is taken
// while a result still waits, as long as that result leaves in the same
// cycle the held command is processed. Registers are written over the APB
// port at byte address 4*index and are meant to change only while the
// block is idle. Pulses are in microseconds; steering and throttle are
// Q1.14.
module esc_arming_slew_limiter
    import esl_pkg::*;
#(
    parameter int SERVO_MIN_US = 1000,
    parameter int SERVO_MAX_US = 2000,
    parameter int ESC_MIN_US   = 1000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    esl_cmd_if.sink           cmd_ch,
    esl_pulse_if.source       pulse_ch
);

    localparam logic signed [14:0] SMIN  = 15'(SERVO_MIN_US);
    localparam logic signed [14:0] SMAX  = 15'(SERVO_MAX_US);
    localparam logic signed [14:0] EMIN  = 15'(ESC_MIN_US);
    localparam logic [11:0]        EMIN_U = 12'(ESC_MIN_US);

    // Configuration registers
    logic [11:0] servo_center_reg;
    logic [10:0] servo_deflect_reg;
    logic [11:0] servo_slew_reg;
    logic [11:0] esc_idle_reg;
    logic [11:0] esc_max_reg;
    logic [11:0] esc_arm_pulse_reg;
    logic [11:0] esc_slew_reg;
    logic [15:0] arm_time_ms_reg;

    // Input stage and controller state
    logic        in_valid_reg;
    esl_cmd_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [11:0] rudder_reg;
    logic [11:0] rudder_next;
    logic [11:0] motor_reg;
    logic [11:0] motor_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] arm_begin_reg;
    logic [31:0] arm_begin_next;

    logic advance;
    logic cfg_write;

    // Datapath intermediates
    logic signed [15:0] steer_c;
    logic signed [15:0] thr_c;
    logic [31:0]        elapsed;
    logic signed [27:0] prod_servo;
    logic signed [27:0] prod_servo_b;
    logic signed [12:0] q_servo;
    logic signed [14:0] tgt_servo_w;
    logic [11:0]        tgt_servo;
    logic signed [12:0] esc_span;
    logic signed [29:0] prod_esc;
    logic signed [29:0] prod_esc_b;
    logic signed [12:0] q_esc;
    logic signed [14:0] tgt_esc_w;
    logic [11:0]        tgt_esc;

    // Move cur toward tgt by at most step.
    function automatic logic [11:0] slew_toward(
        input logic [11:0] cur,
        input logic [11:0] tgt,
        input logic [11:0] step
    );
        logic signed [13:0] d;
        logic signed [13:0] s;
        d = $signed({2'b00, tgt}) - $signed({2'b00, cur});
        s = $signed({2'b00, step});
        if (d > s) begin
            slew_toward = cur + step;
        end
        else if (d < -s) begin
            slew_toward = cur - step;
        end
        else begin
            slew_toward = tgt;
        end
    endfunction

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_center_reg  <= RST_SERVO_CENTER;
            servo_deflect_reg <= RST_SERVO_DEFLECT;
            servo_slew_reg    <= RST_SERVO_SLEW;
            esc_idle_reg      <= RST_ESC_IDLE;
            esc_max_reg       <= RST_ESC_MAX;
            esc_arm_pulse_reg <= RST_ESC_ARM_PULSE;
            esc_slew_reg      <= RST_ESC_SLEW;
            arm_time_ms_reg   <= RST_ARM_TIME_MS;
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:2])
                REG_SERVO_CENTER:  servo_center_reg  <= pwdata[11:0];
                REG_SERVO_DEFLECT: servo_deflect_reg <= pwdata[10:0];
                REG_SERVO_SLEW:    servo_slew_reg    <= pwdata[11:0];
                REG_ESC_IDLE:      esc_idle_reg      <= pwdata[11:0];
                REG_ESC_MAX:       esc_max_reg       <= pwdata[11:0];
                REG_ESC_ARM_PULSE: esc_arm_pulse_reg <= pwdata[11:0];
                REG_ESC_SLEW:      esc_slew_reg      <= pwdata[11:0];
                REG_ARM_TIME_MS:   arm_time_ms_reg   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_SERVO_CENTER:  prdata = DATA_W'(servo_center_reg);
            REG_SERVO_DEFLECT: prdata = DATA_W'(servo_deflect_reg);
            REG_SERVO_SLEW:    prdata = DATA_W'(servo_slew_reg);
            REG_ESC_IDLE:      prdata = DATA_W'(esc_idle_reg);
            REG_ESC_MAX:       prdata = DATA_W'(esc_max_reg);
            REG_ESC_ARM_PULSE: prdata = DATA_W'(esc_arm_pulse_reg);
            REG_ESC_SLEW:      prdata = DATA_W'(esc_slew_reg);
            REG_ARM_TIME_MS:   prdata = DATA_W'(arm_time_ms_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: process the held word when the result slot is free or
    // draining this cycle; take a new word whenever the input register
    // empties.
    // ------------------------------------------------------------------
    assign advance      = in_valid_reg && (!out_valid_reg || pulse_ch.ready);
    assign cmd_ch.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pulse_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ch.ready)
            begin
                in_valid_reg <= cmd_ch.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.ready && cmd_ch.valid)
        begin
            in_data_reg <= cmd_ch.data;
        end
    end

    // ------------------------------------------------------------------
    // Command clamp, failsafe and arming phase
    // ------------------------------------------------------------------
    always_comb
    begin
        if (in_data_reg.steer < Q14_NEG_ONE)
        begin
            steer_c = Q14_NEG_ONE;
        end
        else if (in_data_reg.steer > Q14_ONE)
        begin
            steer_c = Q14_ONE;
        end
        else
        begin
            steer_c = in_data_reg.steer;
        end

        if (in_data_reg.throttle < 16'sd0)
        begin
            thr_c = 16'sd0;
        end
        else if (in_data_reg.throttle > Q14_ONE)
        begin
            thr_c = Q14_ONE;
        end
        else
        begin
            thr_c = in_data_reg.throttle;
        end

        phase_next     = phase_reg;
        arm_begin_next = arm_begin_reg;

        // Failsafe drops both commands and disarms; zero throttle restarts arming below.
        if (in_data_reg.failsafe)
        begin
            steer_c    = 16'sd0;
            thr_c      = 16'sd0;
            phase_next = PHASE_DISARMED;
        end

        // Low throttle while disarmed starts the arming timer; otherwise
        // hold the throttle command at zero.
        if (phase_next == PHASE_DISARMED)
        begin
            if (thr_c <= ARM_THRESHOLD)
            begin
                phase_next     = PHASE_ARMING;
                arm_begin_next = in_data_reg.now_ms;
            end
            else
            begin
                thr_c = 16'sd0;
            end
        end

        // Elapsed time wraps modulo 2^32; arming may finish in the same tick.
        elapsed = in_data_reg.now_ms - arm_begin_next;
        if (phase_next == PHASE_ARMING)
        begin
            thr_c = 16'sd0;
            if (elapsed >= 32'(arm_time_ms_reg))
            begin
                phase_next = PHASE_ARMED;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pulse targets: scale by Q1.14, truncate toward zero (bias negative
    // products before the arithmetic shift), then clamp low bound first.
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_servo   = steer_c * $signed({1'b0, servo_deflect_reg});
        prod_servo_b = prod_servo + (prod_servo[27] ? 28'sd16383 : 28'sd0);
        q_servo      = 13'(prod_servo_b >>> Q14_SHIFT);
        tgt_servo_w  = $signed({3'b000, servo_center_reg}) + 15'(q_servo);
        if (tgt_servo_w < SMIN)
        begin
            tgt_servo = SMIN[11:0];
        end
        else if (tgt_servo_w > SMAX)
        begin
            tgt_servo = SMAX[11:0];
        end
        else
        begin
            tgt_servo = tgt_servo_w[11:0];
        end

        esc_span   = $signed({1'b0, esc_max_reg}) - $signed({1'b0, esc_idle_reg});
        prod_esc   = thr_c * esc_span;
        prod_esc_b = prod_esc + (prod_esc[29] ? 30'sd16383 : 30'sd0);
        q_esc      = 13'(prod_esc_b >>> Q14_SHIFT);
        tgt_esc_w  = $signed({3'b000, esc_idle_reg}) + 15'(q_esc);
        if (phase_next != PHASE_ARMED)
        begin
            tgt_esc = esc_arm_pulse_reg;
        end
        else if (tgt_esc_w < EMIN)
        begin
            tgt_esc = EMIN_U;
        end
        else if (tgt_esc_w > $signed({3'b000, esc_max_reg}))
        begin
            tgt_esc = esc_max_reg;
        end
        else
        begin
            tgt_esc = tgt_esc_w[11:0];
        end

        rudder_next = slew_toward(rudder_reg, tgt_servo, servo_slew_reg);
        motor_next  = slew_toward(motor_reg, tgt_esc, esc_slew_reg);
    end

    // ------------------------------------------------------------------
    // State registers double as the result word.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rudder_reg    <= RST_SERVO_CENTER;
            motor_reg     <= EMIN_U;
            phase_reg     <= PHASE_DISARMED;
            arm_begin_reg <= '0;
        end
        else if (advance)
        begin
            rudder_reg    <= rudder_next;
            motor_reg     <= motor_next;
            phase_reg     <= phase_next;
            arm_begin_reg <= arm_begin_next;
        end
    end

    assign pulse_ch.valid                = out_valid_reg;
    assign pulse_ch.data.rudder_pulse_us = rudder_reg;
    assign pulse_ch.data.motor_pulse_us  = motor_reg;
    assign pulse_ch.data.arm_status      = phase_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word did not produce a result");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(arm_begin_reg)
                     && $stable(rudder_reg) && $stable(motor_reg))
        else $error("controller state moved without a processed word");

    a_failsafe_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.failsafe && (arm_time_ms_reg != 16'd0)
        |=> phase_reg == PHASE_ARMING)
        else $error("failsafe did not restart arming");

    a_motor_slew: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((motor_reg >= $past(motor_reg))
                     ? ((motor_reg - $past(motor_reg)) <= $past(esc_slew_reg))
                     : (($past(motor_reg) - motor_reg) <= $past(esc_slew_reg))))
        else $error("motor pulse moved more than the slew limit");

    a_rudder_slew: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((rudder_reg >= $past(rudder_reg))
                     ? ((rudder_reg - $past(rudder_reg)) <= $past(servo_slew_reg))
                     : (($past(rudder_reg) - rudder_reg) <= $past(servo_slew_reg))))
        else $error("rudder pulse moved more than the slew limit");

endmodule
